>>> sv/grc_pkg.sv
// Grid ray caster package: item structs, register indexes, state codes and helpers.
// No dependencies; imported by grid_ray_caster.
`default_nettype none

package grc_pkg;

    typedef struct packed {
        logic               mode;
        logic [4:0]         cell_x;
        logic [4:0]         cell_y;
        logic [3:0]         cell_value;
        logic [10:0]        column;
        logic signed [15:0] camera_x;
    } grc_in_t;

    typedef struct packed {
        logic [10:0]        out_column;
        logic signed [15:0] draw_start;
        logic signed [15:0] draw_end;
        logic               hit_side;
        logic [3:0]         wall_id;
        logic [5:0]         texture_x;
        logic [15:0]        perp_dist;
        logic               no_hit;
    } grc_out_t;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [2:0] REG_POS_X         = 3'd0;
    localparam logic [2:0] REG_POS_Y         = 3'd1;
    localparam logic [2:0] REG_DIR_X         = 3'd2;
    localparam logic [2:0] REG_DIR_Y         = 3'd3;
    localparam logic [2:0] REG_PLANE_X       = 3'd4;
    localparam logic [2:0] REG_PLANE_Y       = 3'd5;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd6;
    localparam logic [2:0] REG_HORIZON_ROW   = 3'd7;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_CAST  = 1'b1;

    localparam logic [5:0]  DIV_LAST = 6'd44;
    localparam logic [5:0]  MUL_LAST = 6'd10;
    localparam logic [44:0] RECIP_NUM = 45'h1000_0000_0000;
    localparam logic [45:0] DELTA_INF = 46'h2000_0000_0000;

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_RAY   = 13'b0000000000100,
        S_DIVX  = 13'b0000000001000,
        S_DIVY  = 13'b0000000010000,
        S_MUL   = 13'b0000000100000,
        S_WALK  = 13'b0000001000000,
        S_PROBE = 13'b0000010000000,
        S_DIST  = 13'b0000100000000,
        S_TMUL  = 13'b0001000000000,
        S_TEX   = 13'b0010000000000,
        S_DIVH  = 13'b0100000000000,
        S_FIN   = 13'b1000000000000
    } grc_state_t;

    function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
        if (v > 21'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -21'sd32768) begin
            return 16'sh8000;
        end else begin
            return v[15:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> sv/grid_ray_caster.sv
// Cast: two reciprocal divides, a side-distance multiply, DDA steps that each
// read the map memory port and, on a hit, a height divide; a map write gives
// no item.
// One item at a time; the next item is taken while a result waits at the output.
// Reset: synchronous; registers go to defaults, then the map is cleared one
// cell a cycle, all MAP_SIZE*MAP_SIZE cells, before s_ready rises.
`default_nettype none

module grid_ray_caster
    import grc_pkg::*;
#(
    parameter int MAP_SIZE = 32,
    parameter int TEX_SIZE = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire grc_in_t              s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output grc_out_t                  m_data,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [APB_AW-1:0]    paddr,
    input  wire logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready
);

    localparam int CELLS      = MAP_SIZE * MAP_SIZE;
    localparam int AW         = $clog2(CELLS);
    localparam int STEP_LIMIT = 2 * MAP_SIZE;
    localparam int SW         = $clog2(STEP_LIMIT + 1);
    localparam int TPW        = $clog2(TEX_SIZE + 1);

    grc_state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    logic [14:0]        pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic signed [15:0] dir_x_reg, dir_x_next, dir_y_reg, dir_y_next;
    logic signed [15:0] plane_x_reg, plane_x_next, plane_y_reg, plane_y_next;
    logic [10:0]        sh_reg, sh_next;
    logic [11:0]        hr_reg, hr_next;

    logic [10:0]        col_reg, col_next;
    logic signed [15:0] cam_reg, cam_next;
    logic signed [31:0] rx_reg, rx_next, ry_reg, ry_next;
    logic [45:0]        dx_reg, dx_next, dy_reg, dy_next;
    logic [44:0]        div_num_reg, div_num_next, div_q_reg, div_q_next;
    logic [31:0]        div_rem_reg, div_rem_next, div_den_reg, div_den_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [SW-1:0]      step_reg, step_next;
    logic [7:0]         mx_reg, mx_next, my_reg, my_next;
    logic [63:0]        sdx_reg, sdx_next, sdy_reg, sdy_next;
    logic [63:0]        mcx_reg, mcx_next, mcy_reg, mcy_next;
    logic [10:0]        mpx_reg, mpx_next, mpy_reg, mpy_next;
    logic               side_reg, side_next, hit_reg, hit_next;
    logic [3:0]         wall_reg, wall_next;
    logic [15:0]        p8_reg, p8_next;
    logic [23:0]        p16_reg, p16_next;
    logic signed [56:0] tprod_reg, tprod_next;
    logic [5:0]         tex_reg, tex_next;
    logic [18:0]        lh_reg, lh_next;
    grc_out_t           out_reg, out_next;
    logic               m_valid_reg, m_valid_next;

    logic [3:0]    map_mem [CELLS];
    logic [3:0]    rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [3:0]    mem_wdata;

    logic [32:0]        div_shift;
    logic               div_ge;
    logic [31:0]        div_rem_step;
    logic [44:0]        div_q_step;
    logic signed [31:0] px_prod, py_prod;
    logic [31:0]        ry_abs;
    logic               step_x;
    logic [7:0]         nmx, nmy;
    logic               n_out;
    logic [12:0]        walk_lin, wr_lin;
    logic [63:0]        perp;
    logic               perp_big;
    logic [43:0]        frac;
    logic [43+TPW:0]    scaled;
    logic [TPW-1:0]     tval, tsel;
    logic               mirror;
    logic [17:0]        half;
    logic signed [20:0] ds_wide, de_wide;
    logic               cfg_we, fin_load;

    assign pready  = 1'b1;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
    assign cfg_we  = psel & penable & pwrite;

    always_comb begin
        prdata = '0;
        unique case (paddr[4:2])
            REG_POS_X:         prdata = 32'(pos_x_reg);
            REG_POS_Y:         prdata = 32'(pos_y_reg);
            REG_DIR_X:         prdata = 32'(unsigned'(dir_x_reg));
            REG_DIR_Y:         prdata = 32'(unsigned'(dir_y_reg));
            REG_PLANE_X:       prdata = 32'(unsigned'(plane_x_reg));
            REG_PLANE_Y:       prdata = 32'(unsigned'(plane_y_reg));
            REG_SCREEN_HEIGHT: prdata = 32'(sh_reg);
            REG_HORIZON_ROW:   prdata = 32'(hr_reg);
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        div_shift    = {div_rem_reg, div_num_reg[44]};
        div_ge       = div_shift >= {1'b0, div_den_reg};
        div_rem_step = div_ge ? 32'(div_shift - {1'b0, div_den_reg}) : div_shift[31:0];
        div_q_step   = {div_q_reg[43:0], div_ge};

        px_prod = plane_x_reg * cam_reg;
        py_prod = plane_y_reg * cam_reg;
        ry_abs  = ry_reg[31] ? 32'(-ry_reg) : ry_reg;

        step_x = sdx_reg < sdy_reg;
        nmx    = step_x ? mx_reg + (rx_reg[31] ? 8'hFF : 8'h01) : mx_reg;
        nmy    = step_x ? my_reg : my_reg + (ry_reg[31] ? 8'hFF : 8'h01);
        n_out  = nmx[7] || nmy[7] || nmx >= 8'(MAP_SIZE) || nmy >= 8'(MAP_SIZE);
        walk_lin = 13'(nmx[6:0]) * 13'(MAP_SIZE) + 13'(nmy[6:0]);
        wr_lin   = 13'(s_data.cell_x) * 13'(MAP_SIZE) + 13'(s_data.cell_y);

        perp     = side_reg ? sdy_reg - {8'b0, dy_reg, 10'b0}
                            : sdx_reg - {8'b0, dx_reg, 10'b0};
        perp_big = |perp[63:34];

        frac   = tprod_reg[43:0] + {(side_reg ? pos_x_reg[9:0] : pos_y_reg[9:0]), 34'b0};
        scaled = {{TPW{1'b0}}, frac} * (44 + TPW)'(TEX_SIZE);
        tval   = scaled[43+TPW:44];
        mirror = (!side_reg && !rx_reg[31] && rx_reg != 32'sd0) || (side_reg && ry_reg[31]);
        tsel   = mirror ? TPW'(TEX_SIZE - 1) - tval : tval;

        half    = lh_reg[18:1];
        ds_wide = $signed({9'b0, hr_reg}) - $signed({3'b0, half});
        de_wide = $signed({9'b0, hr_reg}) + $signed({3'b0, half});
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        pos_x_next = pos_x_reg;     pos_y_next = pos_y_reg;
        dir_x_next = dir_x_reg;     dir_y_next = dir_y_reg;
        plane_x_next = plane_x_reg; plane_y_next = plane_y_reg;
        sh_next = sh_reg;           hr_next = hr_reg;
        col_next = col_reg;         cam_next = cam_reg;
        rx_next = rx_reg;           ry_next = ry_reg;
        dx_next = dx_reg;           dy_next = dy_reg;
        div_num_next = div_num_reg; div_q_next = div_q_reg;
        div_rem_next = div_rem_reg; div_den_next = div_den_reg;
        cnt_next = cnt_reg;         step_next = step_reg;
        mx_next = mx_reg;           my_next = my_reg;
        sdx_next = sdx_reg;         sdy_next = sdy_reg;
        mcx_next = mcx_reg;         mcy_next = mcy_reg;
        mpx_next = mpx_reg;         mpy_next = mpy_reg;
        side_next = side_reg;       hit_next = hit_reg;
        wall_next = wall_reg;       p8_next = p8_reg;
        p16_next = p16_reg;         tprod_next = tprod_reg;
        tex_next = tex_reg;         lh_next = lh_reg;
        out_next = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        mem_we    = 1'b0;
        mem_addr  = walk_lin[AW-1:0];
        mem_wdata = s_data.cell_value;
        fin_load  = 1'b0;

        if (cfg_we) begin
            unique case (paddr[4:2])
                REG_POS_X:         pos_x_next   = pwdata[14:0];
                REG_POS_Y:         pos_y_next   = pwdata[14:0];
                REG_DIR_X:         dir_x_next   = pwdata[15:0];
                REG_DIR_Y:         dir_y_next   = pwdata[15:0];
                REG_PLANE_X:       plane_x_next = pwdata[15:0];
                REG_PLANE_Y:       plane_y_next = pwdata[15:0];
                REG_SCREEN_HEIGHT: sh_next      = pwdata[10:0];
                REG_HORIZON_ROW:   hr_next      = pwdata[11:0];
                default:           ;
            endcase
        end

        unique case (state_reg)
            S_CLEAR: begin
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                mem_wdata    = 4'd0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(CELLS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                mem_addr = wr_lin[AW-1:0];
                if (s_valid) begin
                    if (s_data.mode == MODE_WRITE) begin
                        mem_we = (7'(s_data.cell_x) < 7'(MAP_SIZE)) &&
                                 (7'(s_data.cell_y) < 7'(MAP_SIZE));
                    end else begin
                        col_next   = s_data.column;
                        cam_next   = s_data.camera_x;
                        state_next = S_RAY;
                    end
                end
            end
            S_RAY: begin
                rx_next = {{2{dir_x_reg[15]}}, dir_x_reg, 14'b0} + px_prod;
                ry_next = {{2{dir_y_reg[15]}}, dir_y_reg, 14'b0} + py_prod;
                mx_next = 8'(pos_x_reg[14:10]);
                my_next = 8'(pos_y_reg[14:10]);
                div_num_next = RECIP_NUM;
                div_den_next = ($signed({{2{dir_x_reg[15]}}, dir_x_reg, 14'b0}) + px_prod) < 0
                             ? 32'(-({{2{dir_x_reg[15]}}, dir_x_reg, 14'b0} + px_prod))
                             : 32'({{2{dir_x_reg[15]}}, dir_x_reg, 14'b0} + px_prod);
                div_rem_next = '0;
                div_q_next   = '0;
                cnt_next     = '0;
                state_next   = S_DIVX;
            end
            S_DIVX, S_DIVY, S_DIVH: begin
                div_rem_next = div_rem_step;
                div_q_next   = div_q_step;
                div_num_next = {div_num_reg[43:0], 1'b0};
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    cnt_next     = '0;
                    div_rem_next = '0;
                    div_q_next   = '0;
                    div_num_next = RECIP_NUM;
                    if (state_reg == S_DIVX) begin
                        dx_next      = (rx_reg == 32'sd0) ? DELTA_INF : {1'b0, div_q_step};
                        div_den_next = ry_abs;
                        state_next   = S_DIVY;
                    end else if (state_reg == S_DIVY) begin
                        dy_next  = (ry_reg == 32'sd0) ? DELTA_INF : {1'b0, div_q_step};
                        mcx_next = {18'b0, dx_reg};
                        mcy_next = {18'b0, ((ry_reg == 32'sd0) ? DELTA_INF
                                                                : {1'b0, div_q_step})};
                        mpx_next = rx_reg[31] ? {1'b0, pos_x_reg[9:0]}
                                              : 11'd1024 - {1'b0, pos_x_reg[9:0]};
                        mpy_next = ry_reg[31] ? {1'b0, pos_y_reg[9:0]}
                                              : 11'd1024 - {1'b0, pos_y_reg[9:0]};
                        sdx_next   = '0;
                        sdy_next   = '0;
                        state_next = S_MUL;
                    end else begin
                        lh_next    = div_q_step[18:0];
                        state_next = S_FIN;
                    end
                end
            end
            S_MUL: begin
                sdx_next = mpx_reg[0] ? sdx_reg + mcx_reg : sdx_reg;
                sdy_next = mpy_reg[0] ? sdy_reg + mcy_reg : sdy_reg;
                mcx_next = {mcx_reg[62:0], 1'b0};
                mcy_next = {mcy_reg[62:0], 1'b0};
                mpx_next = {1'b0, mpx_reg[10:1]};
                mpy_next = {1'b0, mpy_reg[10:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST) begin
                    cnt_next   = '0;
                    step_next  = '0;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (step_x) begin
                    sdx_next  = sdx_reg + {8'b0, dx_reg, 10'b0};
                    side_next = 1'b0;
                end else begin
                    sdy_next  = sdy_reg + {8'b0, dy_reg, 10'b0};
                    side_next = 1'b1;
                end
                mx_next   = nmx;
                my_next   = nmy;
                step_next = step_reg + 1'b1;
                if (n_out) begin
                    hit_next   = 1'b0;
                    state_next = S_FIN;
                end else begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                if (rd_data_reg != 4'd0) begin
                    hit_next   = 1'b1;
                    wall_next  = rd_data_reg;
                    state_next = S_DIST;
                end else if (step_reg == SW'(STEP_LIMIT)) begin
                    hit_next   = 1'b0;
                    state_next = S_FIN;
                end else begin
                    state_next = S_WALK;
                end
            end
            S_DIST: begin
                p8_next    = perp_big ? 16'hFFFF : perp[33:18];
                p16_next   = perp_big ? 24'hFF_FFFF : perp[33:10];
                state_next = S_TMUL;
            end
            S_TMUL: begin
                tprod_next = $signed({1'b0, p16_reg}) * (side_reg ? rx_reg : ry_reg);
                state_next = S_TEX;
            end
            S_TEX: begin
                tex_next     = 6'(tsel);
                div_num_next = 45'({sh_reg, 8'b0});
                div_den_next = (p8_reg == 16'd0) ? 32'd1 : 32'(p8_reg);
                div_rem_next = '0;
                div_q_next   = '0;
                cnt_next     = '0;
                state_next   = S_DIVH;
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    fin_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (fin_load) begin
            out_next            = '0;
            out_next.out_column = col_reg;
            if (hit_reg) begin
                out_next.draw_start = sat16(ds_wide);
                out_next.draw_end   = sat16(de_wide);
                out_next.hit_side   = side_reg;
                out_next.wall_id    = wall_reg;
                out_next.texture_x  = tex_reg;
                out_next.perp_dist  = p8_reg;
            end else begin
                out_next.no_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= map_mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            pos_x_reg   <= 15'd20480;
            pos_y_reg   <= 15'd12288;
            dir_x_reg   <= -16'sd16384;
            dir_y_reg   <= 16'sd0;
            plane_x_reg <= 16'sd0;
            plane_y_reg <= 16'sd11469;
            sh_reg      <= 11'd800;
            hr_reg      <= 12'd0;
            cnt_reg     <= '0;
            step_reg    <= '0;
            hit_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            dir_x_reg   <= dir_x_next;
            dir_y_reg   <= dir_y_next;
            plane_x_reg <= plane_x_next;
            plane_y_reg <= plane_y_next;
            sh_reg      <= sh_next;
            hr_reg      <= hr_next;
            cnt_reg     <= cnt_next;
            step_reg    <= step_next;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg     <= col_next;
        cam_reg     <= cam_next;
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        div_num_reg <= div_num_next;
        div_q_reg   <= div_q_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
        mx_reg      <= mx_next;
        my_reg      <= my_next;
        sdx_reg     <= sdx_next;
        sdy_reg     <= sdy_next;
        mcx_reg     <= mcx_next;
        mcy_reg     <= mcy_next;
        mpx_reg     <= mpx_next;
        mpy_reg     <= mpy_next;
        side_reg    <= side_next;
        wall_reg    <= wall_next;
        p8_reg      <= p8_next;
        p16_reg     <= p16_next;
        tprod_reg   <= tprod_next;
        tex_reg     <= tex_next;
        lh_reg      <= lh_next;
        out_reg     <= out_next;
    end

`ifndef SYNTHESIS
    a_probe_in_map: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE) |-> (!mx_reg[7] && mx_reg < 8'(MAP_SIZE) &&
                                    !my_reg[7] && my_reg < 8'(MAP_SIZE)))
        else $error("probe outside map");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIVX || state_reg == S_DIVY || state_reg == S_DIVH) |->
        (div_den_reg == 32'd0 || div_rem_reg < div_den_reg))
        else $error("divider remainder out of range");

    a_step_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK || state_reg == S_PROBE) |-> (step_reg <= SW'(STEP_LIMIT)))
        else $error("step count past limit");

    a_no_hit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.no_hit) |->
        (out_reg.perp_dist == 16'd0 && out_reg.wall_id == 4'd0 && !out_reg.hit_side))
        else $error("no-hit item carries wall data");
`endif

endmodule

`default_nettype wire

>>> sim/grc_checker.sv
// Grid ray caster checker: predicts each cast result from its own map and register copy.
// Depends on grc_pkg; watches the input, result and register write ports of the block.
`timescale 1ns / 100ps

module grc_checker
    import grc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire grc_in_t           s_data,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire grc_out_t          m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic              pready,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output int                     fail_count,
    output int                     pending,
    output int                     casts_seen,
    output int                     misses_seen
);

    localparam int MAP_N = 32;
    localparam int TEX_N = 64;

    logic [3:0]  wall_map [MAP_N*MAP_N];
    logic [14:0] cam_px, cam_py;
    logic signed [15:0] view_dx, view_dy, pln_x, pln_y;
    logic [10:0] scr_h;
    logic [11:0] horizon;
    grc_out_t    cast_queue [$];

    function automatic logic [63:0] step_of(input longint r);
        longint unsigned m;
        if (r == 0) return 64'd1 << 45;
        m = r < 0 ? -r : r;
        return (64'd1 << 44) / m;
    endfunction

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic grc_out_t cast_ray(input grc_in_t it);
        grc_out_t r;
        longint rx, ry, mx, my, sx, sy, lh;
        longint unsigned dx, dy, sdx, sdy, fx, fy, perp, p8, p16, frac, tex;
        logic side, hit;
        logic [3:0] wall;
        rx = longint'(view_dx) * 16384 + longint'(pln_x) * longint'(it.camera_x);
        ry = longint'(view_dy) * 16384 + longint'(pln_y) * longint'(it.camera_x);
        dx = step_of(rx);
        dy = step_of(ry);
        mx = longint'(cam_px[14:10]);
        my = longint'(cam_py[14:10]);
        fx = 64'(cam_px[9:0]);
        fy = 64'(cam_py[9:0]);
        if (rx < 0) begin sx = -1; sdx = fx * dx; end
        else begin sx = 1; sdx = (1024 - fx) * dx; end
        if (ry < 0) begin sy = -1; sdy = fy * dy; end
        else begin sy = 1; sdy = (1024 - fy) * dy; end
        side = 1'b0;
        hit = 1'b0;
        wall = 4'd0;
        for (int i = 0; i < 2*MAP_N; i++) begin
            if (sdx < sdy) begin
                sdx += dx << 10; mx += sx; side = 1'b0;
            end else begin
                sdy += dy << 10; my += sy; side = 1'b1;
            end
            if (mx < 0 || my < 0 || mx >= MAP_N || my >= MAP_N) break;
            wall = wall_map[mx*MAP_N + my];
            if (wall != 0) begin
                hit = 1'b1;
                break;
            end
        end
        r = '0;
        r.out_column = it.column;
        if (!hit) begin
            r.no_hit = 1'b1;
            return r;
        end
        perp = side ? sdy - (dy << 10) : sdx - (dx << 10);
        p8 = perp >> 18;
        if (p8 > 65535) p8 = 65535;
        lh = (longint'(scr_h) << 8) / (p8 == 0 ? 1 : p8);
        r.draw_start = clip16(longint'(horizon) - lh / 2);
        r.draw_end = clip16(longint'(horizon) + lh / 2);
        r.hit_side = side;
        r.wall_id = wall;
        p16 = perp >> 10;
        if (p16 > 64'hFFFFFF) p16 = 64'hFFFFFF;
        if (!side) frac = longint'(p16) * ry + (longint'(cam_py) << 34);
        else frac = longint'(p16) * rx + (longint'(cam_px) << 34);
        frac &= (64'd1 << 44) - 1;
        tex = (frac * TEX_N) >> 44;
        if ((!side && rx > 0) || (side && ry < 0)) tex = TEX_N - 1 - tex;
        r.texture_x = tex[5:0];
        r.perp_dist = p8[15:0];
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        grc_out_t want;
        if (!aresetn) begin
            foreach (wall_map[i]) wall_map[i] <= '0;
            cam_px <= 15'd20480; cam_py <= 15'd12288;
            view_dx <= -16'sd16384; view_dy <= '0;
            pln_x <= '0; pln_y <= 16'sd11469;
            scr_h <= 11'd800; horizon <= '0;
            cast_queue.delete();
            fail_count <= 0; casts_seen <= 0; misses_seen <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_POS_X:         cam_px <= pwdata[14:0];
                    REG_POS_Y:         cam_py <= pwdata[14:0];
                    REG_DIR_X:         view_dx <= pwdata[15:0];
                    REG_DIR_Y:         view_dy <= pwdata[15:0];
                    REG_PLANE_X:       pln_x <= pwdata[15:0];
                    REG_PLANE_Y:       pln_y <= pwdata[15:0];
                    REG_SCREEN_HEIGHT: scr_h <= pwdata[10:0];
                    REG_HORIZON_ROW:   horizon <= pwdata[11:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_data.mode == MODE_WRITE)
                    wall_map[s_data.cell_x*MAP_N + s_data.cell_y] <= s_data.cell_value;
                else
                    cast_queue.insert(cast_queue.size(), cast_ray(s_data));
            end
            if (m_valid && m_ready) begin
                if (cast_queue.size() == 0) begin
                    $error("unexpected result item, column %0d", m_data.out_column);
                    fail_count <= fail_count + 1;
                end else begin
                    want = cast_queue.pop_front();
                    casts_seen <= casts_seen + 1;
                    if (m_data.no_hit) misses_seen <= misses_seen + 1;
                    if (m_data !== want) begin
                        fail_count <= fail_count + 1;
                        if (m_data.out_column !== want.out_column)
                            $error("out_column exp %0d got %0d", want.out_column,
                                   m_data.out_column);
                        if (m_data.draw_start !== want.draw_start)
                            $error("draw_start exp %0d got %0d", want.draw_start,
                                   m_data.draw_start);
                        if (m_data.draw_end !== want.draw_end)
                            $error("draw_end exp %0d got %0d", want.draw_end,
                                   m_data.draw_end);
                        if (m_data.hit_side !== want.hit_side)
                            $error("hit_side exp %0d got %0d", want.hit_side,
                                   m_data.hit_side);
                        if (m_data.wall_id !== want.wall_id)
                            $error("wall_id exp %0d got %0d", want.wall_id, m_data.wall_id);
                        if (m_data.texture_x !== want.texture_x)
                            $error("texture_x exp %0d got %0d", want.texture_x,
                                   m_data.texture_x);
                        if (m_data.perp_dist !== want.perp_dist)
                            $error("perp_dist exp %0d got %0d", want.perp_dist,
                                   m_data.perp_dist);
                        if (m_data.no_hit !== want.no_hit)
                            $error("no_hit exp %0d got %0d", want.no_hit, m_data.no_hit);
                    end
                end
            end
        end
    end

    // queue size after this edge's updates
    always_comb pending = cast_queue.size();

endmodule

>>> sim/tb.sv
// Grid ray caster testbench top: reset, register writes, map and cast stimulus, verdict.
// Depends on grc_pkg, grid_ray_caster and grc_checker.
`timescale 1ns / 100ps

module tb;
    import grc_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    grc_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    grc_out_t m_data;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;
    int fail_count, pending, casts_seen, misses_seen;
    int burst_left = 0;
    int stall_mode = 0;
    int fed = 0;

    always #1 aclk = ~aclk;

    grid_ray_caster dut (.*);

    grc_checker checker_i (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .fail_count, .pending, .casts_seen, .misses_seen
    );

    // receiver: phases of always-ready, random, and heavy stall
    always @(negedge aclk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_item(input grc_in_t it);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40)) @(negedge aclk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_data <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        fed++;
        @(negedge aclk);
        if (burst_left == 0) s_valid <= 1'b0;
    endtask

    task automatic map_write(input int x, input int y, input int v);
        grc_in_t it;
        it = '0;
        it.mode = MODE_WRITE;
        it.cell_x = 5'(x); it.cell_y = 5'(y); it.cell_value = 4'(v);
        send_item(it);
    endtask

    task automatic cast(input int col, input int cam);
        grc_in_t it;
        it = grc_in_t'($urandom());
        it.mode = MODE_CAST;
        it.column = 11'(col);
        it.camera_x = 16'(cam);
        send_item(it);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    task automatic random_setting();
        reg_write(REG_POS_X, $urandom_range(1024, 31743) | ($urandom_range(0, 1) << 16));
        reg_write(REG_POS_Y, $urandom_range(1024, 31743));
        reg_write(REG_DIR_X, $urandom());
        reg_write(REG_DIR_Y, $urandom());
        reg_write(REG_PLANE_X, $urandom_range(0, 3) == 0 ? 0 : $urandom());
        reg_write(REG_PLANE_Y, $urandom());
        reg_write(REG_SCREEN_HEIGHT, $urandom_range(1, 2047));
        reg_write(REG_HORIZON_ROW, $urandom_range(0, 4094));
    endtask

    function automatic int rand_cam();
        case ($urandom_range(0, 5))
            0: return 16384;
            1: return -16384;
            2: return 0;
            3: return $signed(16'($urandom()));
            default: return $urandom_range(0, 32768) - 16384;
        endcase
    endfunction

    initial begin
        #10000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: default camera with empty map runs off the edge, then hits walls written on two map edges
        cast(0, 0);
        cast(2047, 16384);
        map_write(0, 0, 15);
        map_write(31, 31, 1);
        map_write(40 % 32, 0, 0);
        for (int i = 0; i < 32; i++) map_write(0, i, 1 + i % 15);
        for (int i = 0; i < 32; i++) map_write(i, 31, 9);
        cast(1, -16384);
        cast(2, 16384);
        cast(3, -1);
        map_write(4, 12, 7);
        cast(4, 0);
        drain();

        // extremes: camera pinned in a corner, axis-aligned, tiny and huge screens
        reg_write(REG_POS_X, 32'h7FFF);
        reg_write(REG_POS_Y, 32'h0000);
        reg_write(REG_DIR_X, 32'h8000);
        reg_write(REG_DIR_Y, 32'h7FFF);
        reg_write(REG_PLANE_X, 32'h7FFF);
        reg_write(REG_PLANE_Y, 32'h8000);
        reg_write(REG_SCREEN_HEIGHT, 32'd2047);
        reg_write(REG_HORIZON_ROW, 32'd4094);
        cast(5, 16384);
        cast(6, -16384);
        cast(7, 0);
        drain();
        reg_write(REG_POS_X, 32'd1024 + 512);
        reg_write(REG_POS_Y, 32'd1024 + 1023);
        reg_write(REG_DIR_X, 32'h8000);
        reg_write(REG_DIR_Y, 32'h0);
        reg_write(REG_PLANE_X, 32'h0);
        reg_write(REG_PLANE_Y, 32'h0);
        reg_write(REG_SCREEN_HEIGHT, 32'd1);
        reg_write(REG_HORIZON_ROW, 32'd0);
        cast(8, 0);
        cast(9, 16384);
        drain();

        // random phases: sparse walls, random camera settings
        while (fed < 1750) begin
            random_setting();
            for (int k = 0; k < 150 && fed < 1750; k++) begin
                if ($urandom_range(0, 2) == 0)
                    map_write($urandom_range(0, 31), $urandom_range(0, 31),
                              $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15));
                else
                    cast($urandom_range(0, 2047), rand_cam());
            end
            drain();
        end

        $display("Drove %0d items; %0d cast results checked, %0d of them missed every wall.",
                 fed, casts_seen, misses_seen);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
